[hw/rtl/assert_macros.svh]
// Assertion macros for the RTL of the tile writer, included by the top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define DFTW_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define DFTW_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define DFTW_ASSERT(lbl, prop, msg)
`define DFTW_NEVER(lbl, expr, msg)
`endif
`endif

[hw/rtl/dftw_pkg.sv]
// Types and constants shared by the decimal field tile writer.
package dftw_pkg;

  localparam logic REG_DIGIT_BASE = 1'b0;
  localparam logic REG_BLANK_TILE = 1'b1;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;
  localparam int QCNT_W      = 2;

  // Reciprocal of ten for 16-bit operands: q = (v * RECIP10) >> RECIP_SHIFT.
  localparam logic [31:0] RECIP10     = 32'd52429;
  localparam int          RECIP_SHIFT = 19;

  typedef struct packed {
    logic [7:0]  col;
    logic [7:0]  row;
    logic [15:0] number;
    logic [3:0]  width;
  } dftw_cmd_t;

  typedef struct packed {
    logic [7:0] col;
    logic [7:0] row;
    logic [7:0] tile;
    logic       last;
  } dftw_wr_t;

  typedef struct packed {
    logic full;
    logic empty;
  } dftw_qstat_t;

endpackage

[hw/rtl/dftw_front.sv]
// Front end: accepts input words, clamps the field width and drops empty fields.
module dftw_front import dftw_pkg::*; #(
  parameter int MAX_FIELD_WIDTH = 8
) (
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,
  input  dftw_qstat_t q_stat,
  output logic        push,
  output dftw_cmd_t   push_cmd
);

  localparam logic [3:0] CLAMP_W = (MAX_FIELD_WIDTH > 15) ? 4'd15 : 4'(MAX_FIELD_WIDTH);

  logic [3:0] raw_w;
  logic [3:0] eff_w;

  assign raw_w = in_tdata[35:32];
  assign eff_w = (raw_w > CLAMP_W) ? CLAMP_W : raw_w;

  assign in_tready = !q_stat.full;

  always_comb begin
    push_cmd.col    = in_tdata[7:0];
    push_cmd.row    = in_tdata[15:8];
    push_cmd.number = in_tdata[31:16];
    push_cmd.width  = eff_w;
  end

  // A zero-width field causes no writes, so the word is taken and dropped here.
  assign push = in_tvalid && in_tready && (eff_w != 4'd0);

endmodule

[hw/rtl/dftw_queue.sv]
// Short command queue between the front end and the write sequencer.
module dftw_queue import dftw_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  dftw_cmd_t   push_cmd,
  input  logic        pop,
  output dftw_cmd_t   head,
  output dftw_qstat_t stat
);

  dftw_cmd_t         mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r;
  logic              do_push;
  logic              do_pop;

  assign stat.full  = (cnt_r == QCNT_W'(QUEUE_DEPTH));
  assign stat.empty = (cnt_r == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign head       = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

[hw/rtl/dftw_back.sv]
// Write sequencer: emits the blank writes, then the decimal digits, one word a cycle while the output is not stalled.
module dftw_back import dftw_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cmd_valid,
  input  dftw_cmd_t  cmd,
  output logic       cmd_pop,
  input  logic [7:0] digit_tile_base,
  input  logic [7:0] blank_tile,
  output logic       out_valid,
  input  logic       out_ready,
  output dftw_wr_t   out_wr
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_BLANK,
    ST_DIGIT
  } state_t;

  state_t      state_r;
  logic [7:0]  col_r;
  logic [7:0]  row_r;
  logic [15:0] val_r;
  logic [3:0]  width_r;
  logic [3:0]  pos_r;
  logic        out_valid_r;
  dftw_wr_t    out_wr_r;

  logic        adv;
  logic [31:0] prod;
  logic [15:0] quot;
  logic [15:0] quot_x10;
  logic [15:0] rem_full;
  logic [7:0]  cell_col;
  logic [7:0]  digit_tile;
  logic        is_last;

  assign adv = !out_valid_r || out_ready;

  // Divide by ten through the reciprocal; exact over the whole 16-bit range.
  assign prod       = {16'd0, val_r} * RECIP10;
  assign quot       = 16'(prod[31:RECIP_SHIFT]);
  assign quot_x10   = (quot << 3) + (quot << 1);
  assign rem_full   = val_r - quot_x10;
  assign cell_col   = col_r + {4'd0, pos_r};
  assign digit_tile = digit_tile_base + {4'd0, rem_full[3:0]};
  assign is_last    = (pos_r == 4'd0) || (quot == 16'd0);

  assign cmd_pop   = (state_r == ST_IDLE) && cmd_valid;
  assign out_valid = out_valid_r;
  assign out_wr    = out_wr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      // A new word is loaded whenever the sequencer is busy and the register is free.
      if ((state_r != ST_IDLE) && adv) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (cmd_valid) begin
            col_r   <= cmd.col;
            row_r   <= cmd.row;
            val_r   <= cmd.number;
            width_r <= cmd.width;
            pos_r   <= cmd.width - 4'd1;
            state_r <= ST_BLANK;
          end
        end
        ST_BLANK: begin
          if (adv) begin
            out_wr_r    <= '{col: cell_col, row: row_r, tile: blank_tile, last: 1'b0};
            if (pos_r == 4'd0) begin
              pos_r   <= width_r - 4'd1;
              state_r <= ST_DIGIT;
            end else begin
              pos_r <= pos_r - 4'd1;
            end
          end
        end
        ST_DIGIT: begin
          if (adv) begin
            out_wr_r    <= '{col: cell_col, row: row_r, tile: digit_tile, last: is_last};
            val_r       <= quot;
            pos_r       <= pos_r - 4'd1;
            if (is_last) begin
              state_r <= ST_IDLE;
            end
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

[hw/rtl/decimal_field_tile_writer_top.sv]
// Top level of the decimal field tile writer: configuration registers and assertions.
//
//   channel  direction  payload
//   in_      slave      start_column, row, number, field_width in tdata
//   out_     master     cell_column, cell_row, tile_index in tdata; last in tlast
//   cfg_     write      digit_tile_base (index 0), blank_tile (index 1)
//
// An input word with clamped width w and d decimal digits (d at most w and at
// most five) takes an idle step, w blank writes and then d digit writes in the
// sequencer, one write word per cycle from the output register unless stalled.
// A two-entry command queue lets the front take further words while the sequencer
// works. Reset is synchronous and clears control state and both configuration
// registers. A stall on out_tready holds the sequencer; a full queue drops in_tready.
`include "assert_macros.svh"
module decimal_field_tile_writer_top import dftw_pkg::*; #(
  parameter int MAX_FIELD_WIDTH = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // start_column, row, number, field_width, zero pad
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // cell_column, cell_row, tile_index
  output logic        out_tlast,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_wdata
);

  logic [7:0]  digit_base_r;
  logic [7:0]  blank_tile_r;
  logic        push;
  dftw_cmd_t   push_cmd;
  logic        pop;
  dftw_cmd_t   head;
  dftw_qstat_t q_stat;
  dftw_wr_t    wr;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      digit_base_r <= 8'd0;
      blank_tile_r <= 8'd0;
    end else if (cfg_we) begin
      if (cfg_index == REG_DIGIT_BASE) begin
        digit_base_r <= cfg_wdata;
      end
      if (cfg_index == REG_BLANK_TILE) begin
        blank_tile_r <= cfg_wdata;
      end
    end
  end

  dftw_front #(
    .MAX_FIELD_WIDTH(MAX_FIELD_WIDTH)
  ) u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .q_stat    (q_stat),
    .push      (push),
    .push_cmd  (push_cmd)
  );

  dftw_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .stat     (q_stat)
  );

  dftw_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd_valid       (!q_stat.empty),
    .cmd             (head),
    .cmd_pop         (pop),
    .digit_tile_base (digit_base_r),
    .blank_tile      (blank_tile_r),
    .out_valid       (out_tvalid),
    .out_ready       (out_tready),
    .out_wr          (wr)
  );

  assign out_tdata = {wr.tile, wr.row, wr.col};
  assign out_tlast = wr.last;

  `DFTW_NEVER(a_queue_flags, q_stat.full && q_stat.empty, "queue both full and empty")
  `DFTW_ASSERT(a_no_empty_push, push |-> (push_cmd.width != 4'd0), "zero-width field queued")
  `DFTW_NEVER(a_pop_when_empty, pop && q_stat.empty, "sequencer popped an empty queue")

endmodule
